// ===== design/bsm_pkg.sv =====
// ---------------------------------------------------------------------------
// bsm_pkg - shared types and constants of the byte stack machine executor
// Sizes, opcode and fault codes, and the record types between the units.
// ---------------------------------------------------------------------------
package bsm_pkg;

    // machine sizes
    localparam int STACK_DEPTH   = 1024;
    localparam int REG_COUNT     = 8;
    localparam int PROGRAM_WORDS = 2048;

    // derived widths
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
    localparam int REG_AW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // field widths
    localparam int ADDR_W = 12;
    localparam int WORD_W = 8;
    localparam int ERR_W  = 3;

    // instruction word layout
    localparam int CONST_BIT = 7;

    // opcodes
    localparam logic [6:0] OP_NOP  = 7'd0;
    localparam logic [6:0] OP_POP  = 7'd1;
    localparam logic [6:0] OP_ADD  = 7'd2;
    localparam logic [6:0] OP_SUB  = 7'd3;
    localparam logic [6:0] OP_LDR  = 7'd4;
    localparam logic [6:0] OP_WTR  = 7'd5;
    localparam logic [6:0] OP_JMP  = 7'd6;
    localparam logic [6:0] OP_OUT  = 7'd7;
    localparam logic [6:0] OP_LAST = OP_OUT;

    // fault codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 3'd0,
        ERR_OPCODE = 3'd1,
        ERR_UNDER  = 3'd2,
        ERR_OVER   = 3'd3,
        ERR_REG    = 3'd4
    } t_err;

    // state changes decided for one instruction
    typedef struct packed {
        logic                stk_we;
        logic [STACK_AW-1:0] stk_waddr;
        logic [WORD_W-1:0]   stk_wdata;
        logic [DEPTH_W-1:0]  depth;
        logic                reg_we;
        logic [REG_AW-1:0]   reg_idx;
        logic [WORD_W-1:0]   reg_wdata;
        logic [ADDR_W-1:0]   ip;
        logic                stop_set;
        t_err                err;
    } t_upd;

    // result of one request
    typedef struct packed {
        logic [ADDR_W-1:0] next_address;
        logic              finished;
        logic              char_valid;
        logic [WORD_W-1:0] char_value;
        logic [ERR_W-1:0]  error_code;
    } t_result;

    // operands an opcode needs on the stack
    function automatic logic [1:0] min_operands(input logic [6:0] op);
        logic [1:0] n;
        case (op)
            OP_NOP:  n = 2'd0;
            OP_POP:  n = 2'd1;
            OP_ADD:  n = 2'd2;
            OP_SUB:  n = 2'd2;
            OP_LDR:  n = 2'd1;
            OP_WTR:  n = 2'd2;
            OP_JMP:  n = 2'd2;
            OP_OUT:  n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== design/bsm_stack_ram.sv =====
// ---------------------------------------------------------------------------
// bsm_stack_ram - operand stack storage
// One write port and two registered read ports for top and second entry.
// ---------------------------------------------------------------------------
module bsm_stack_ram
    import bsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [STACK_AW-1:0] i_waddr,
    input  logic [WORD_W-1:0]   i_wdata,
    input  logic                i_re,
    input  logic [STACK_AW-1:0] i_raddr_a,
    input  logic [STACK_AW-1:0] i_raddr_b,
    output logic [WORD_W-1:0]   o_rdata_a,
    output logic [WORD_W-1:0]   o_rdata_b
);

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rdata_a;
    logic [WORD_W-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/bsm_regfile.sv =====
// ---------------------------------------------------------------------------
// bsm_regfile - general register file
// Cleared by reset, one write port and one read port.
// ---------------------------------------------------------------------------
module bsm_regfile
    import bsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [REG_AW-1:0] i_widx,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [REG_AW-1:0] i_ridx,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_regs [REG_COUNT];

    // register update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= '0;
            end
        end else if (i_we) begin
            r_regs[i_widx] <= i_wdata;
        end
    end

    // read, index range checked by the caller
    assign o_rdata = r_regs[i_ridx];

endmodule

// ===== design/bsm_exec.sv =====
// ---------------------------------------------------------------------------
// bsm_exec - instruction execute unit
// Decodes one word, checks faults and works out the state changes and result.
// ---------------------------------------------------------------------------
module bsm_exec
    import bsm_pkg::*;
(
    input  logic [WORD_W-1:0]  i_word,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic [ADDR_W-1:0]  i_ip,
    input  logic [ADDR_W-1:0]  i_plen,
    input  logic               i_stopped,
    input  t_err               i_err_latched,
    input  logic [WORD_W-1:0]  i_tos,
    input  logic [WORD_W-1:0]  i_nos,
    input  logic [WORD_W-1:0]  i_reg_rdata,
    output t_upd               o_upd,
    output t_result            o_res
);

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [8:0]         REG_LIMIT  = 9'(REG_COUNT);

    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [6:0]         op;
    logic               active;
    logic               reg_bad;
    logic               ch_valid;
    logic [WORD_W-1:0]  ch_value;
    t_upd               upd;

    assign depth_m1 = i_depth - DEPTH_W'(1);
    assign depth_m2 = i_depth - DEPTH_W'(2);
    assign op       = i_word[6:0];
    assign active   = !i_stopped && (i_ip < i_plen);
    assign reg_bad  = {1'b0, i_tos} >= REG_LIMIT;

    // decode and execute
    always_comb begin
        upd.stk_we    = 1'b0;
        upd.stk_waddr = i_depth[STACK_AW-1:0];
        upd.stk_wdata = '0;
        upd.depth     = i_depth;
        upd.reg_we    = 1'b0;
        upd.reg_idx   = i_tos[REG_AW-1:0];
        upd.reg_wdata = i_nos;
        upd.ip        = i_ip + ADDR_W'(1);
        upd.stop_set  = 1'b0;
        upd.err       = ERR_OK;
        ch_valid      = 1'b0;
        ch_value      = '0;

        if (i_word[CONST_BIT]) begin
            // push constant
            if (i_depth >= DEPTH_FULL) begin
                upd.err = ERR_OVER;
            end else begin
                upd.stk_we    = 1'b1;
                upd.stk_wdata = {1'b0, i_word[6:0]};
                upd.depth     = i_depth + DEPTH_W'(1);
            end
        end else if (op > OP_LAST) begin
            upd.err = ERR_OPCODE;
        end else if (i_depth < {{(DEPTH_W-2){1'b0}}, min_operands(op)}) begin
            upd.err = ERR_UNDER;
        end else begin
            case (op)
                OP_NOP: begin
                end
                OP_POP: begin
                    upd.depth = depth_m1;
                end
                OP_ADD: begin
                    upd.stk_we    = 1'b1;
                    upd.stk_waddr = depth_m2[STACK_AW-1:0];
                    upd.stk_wdata = i_nos + i_tos;
                    upd.depth     = depth_m1;
                end
                OP_SUB: begin
                    upd.stk_we    = 1'b1;
                    upd.stk_waddr = depth_m2[STACK_AW-1:0];
                    upd.stk_wdata = i_nos - i_tos;
                    upd.depth     = depth_m1;
                end
                OP_LDR: begin
                    if (reg_bad) begin
                        upd.err = ERR_REG;
                    end else begin
                        upd.stk_we    = 1'b1;
                        upd.stk_waddr = depth_m1[STACK_AW-1:0];
                        upd.stk_wdata = i_reg_rdata;
                    end
                end
                OP_WTR: begin
                    if (reg_bad) begin
                        upd.err = ERR_REG;
                    end else begin
                        upd.reg_we = 1'b1;
                        upd.depth  = depth_m2;
                    end
                end
                OP_JMP: begin
                    if (i_nos == '0) begin
                        upd.ip = ADDR_W'(i_tos);
                    end
                    upd.depth = depth_m2;
                end
                default: begin
                    // character output
                    ch_valid  = 1'b1;
                    ch_value  = i_tos;
                    upd.depth = depth_m1;
                end
            endcase
        end

        // fault or ignored word leaves stack, registers, depth and ip as they were
        if (!active || upd.err != ERR_OK) begin
            upd.stk_we = 1'b0;
            upd.reg_we = 1'b0;
            upd.depth  = i_depth;
            upd.ip     = i_ip;
            ch_valid   = 1'b0;
            ch_value   = '0;
        end
        if (!active) begin
            upd.err = ERR_OK;
        end
        upd.stop_set = (upd.err != ERR_OK);
    end

    // result fields
    always_comb begin
        o_res.next_address = upd.ip;
        o_res.finished     = (upd.ip >= i_plen);
        o_res.char_valid   = ch_valid;
        o_res.char_value   = ch_value;
        if (upd.stop_set) begin
            o_res.error_code = upd.err;
        end else if (i_stopped) begin
            o_res.error_code = i_err_latched;
        end else begin
            o_res.error_code = ERR_OK;
        end
    end

    assign o_upd = upd;

endmodule

// ===== design/byte_stack_machine_executor_top.sv =====
// ---------------------------------------------------------------------------
// byte_stack_machine_executor_top - 8-bit stack machine executor
// Runs one pre-decoded instruction word per request, keeps the stack in a
// synchronous RAM and reports the next fetch address.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  in        | in        | i_in_valid / o_in_stall    | i_instr_word
//  out       | out       | o_out_valid / i_out_stall  | o_next_address, o_finished,
//            |           |                            | o_char_valid, o_char_value,
//            |           |                            | o_error_code
//  cfg       | in        | i_cfg_we                   | i_cfg_wdata (program length)
//
// One request per cycle sustained while out is not stalled. The stack RAM is
// read in the cycle a request is taken and written back when that word executes,
// where the following request's read is issued; a same-entry overlap is forwarded
// from the write. A result is registered from the execute stage.
// Reset is synchronous and clears control state and the register file; the
// stack RAM needs no clearing. A stalled result holds execute, which stalls in.
// ---------------------------------------------------------------------------
module byte_stack_machine_executor_top
    import bsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [WORD_W-1:0] i_instr_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_next_address,
    output logic              o_finished,
    output logic              o_char_valid,
    output logic [WORD_W-1:0] o_char_value,
    output logic [ERR_W-1:0]  o_error_code,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata
);

    // control and machine state
    logic               r_vld;
    logic [WORD_W-1:0]  r_word;
    logic [DEPTH_W-1:0] r_depth;
    logic [ADDR_W-1:0]  r_ip;
    logic [ADDR_W-1:0]  r_plen;
    logic               r_stopped;
    t_err               r_err;
    logic               r_fwd_t;
    logic               r_fwd_s;
    logic [WORD_W-1:0]  r_fwd_data;
    logic               r_out_valid;
    t_result            r_res;

    logic               n_vld;
    logic               n_fwd_t;
    logic               n_fwd_s;
    logic [ADDR_W-1:0]  n_plen;

    logic               out_free;
    logic               exec_go;
    logic               in_acc;
    logic [DEPTH_W-1:0] rd_depth;
    logic [DEPTH_W-1:0] rd_depth_m1;
    logic [DEPTH_W-1:0] rd_depth_m2;
    logic [WORD_W-1:0]  ram_t;
    logic [WORD_W-1:0]  ram_s;
    logic [WORD_W-1:0]  tos;
    logic [WORD_W-1:0]  nos;
    logic [WORD_W-1:0]  reg_rdata;
    logic               stk_we;
    t_upd               upd;
    t_result            res;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_go    = r_vld && out_free;
    assign o_in_stall = r_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign stk_we     = exec_go && upd.stk_we;

    // read addresses follow the depth left by the word in execute
    assign rd_depth    = exec_go ? upd.depth : r_depth;
    assign rd_depth_m1 = rd_depth - DEPTH_W'(1);
    assign rd_depth_m2 = rd_depth - DEPTH_W'(2);

    // forwarding of a write to an entry being read
    assign n_fwd_t = stk_we && (upd.stk_waddr == rd_depth_m1[STACK_AW-1:0]);
    assign n_fwd_s = stk_we && (upd.stk_waddr == rd_depth_m2[STACK_AW-1:0]);
    assign tos     = r_fwd_t ? r_fwd_data : ram_t;
    assign nos     = r_fwd_s ? r_fwd_data : ram_s;

    // execute stage occupancy
    always_comb begin
        if (in_acc) begin
            n_vld = 1'b1;
        end else if (exec_go) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    // program length, saturated
    assign n_plen = (int'(i_cfg_wdata) > PROGRAM_WORDS) ? ADDR_W'(PROGRAM_WORDS)
                                                        : i_cfg_wdata;

    bsm_stack_ram u_stack (
        .i_clk     (i_clk),
        .i_we      (stk_we),
        .i_waddr   (upd.stk_waddr),
        .i_wdata   (upd.stk_wdata),
        .i_re      (in_acc),
        .i_raddr_a (rd_depth_m1[STACK_AW-1:0]),
        .i_raddr_b (rd_depth_m2[STACK_AW-1:0]),
        .o_rdata_a (ram_t),
        .o_rdata_b (ram_s)
    );

    bsm_regfile u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (exec_go && upd.reg_we),
        .i_widx  (upd.reg_idx),
        .i_wdata (upd.reg_wdata),
        .i_ridx  (tos[REG_AW-1:0]),
        .o_rdata (reg_rdata)
    );

    bsm_exec u_exec (
        .i_word        (r_word),
        .i_depth       (r_depth),
        .i_ip          (r_ip),
        .i_plen        (r_plen),
        .i_stopped     (r_stopped),
        .i_err_latched (r_err),
        .i_tos         (tos),
        .i_nos         (nos),
        .i_reg_rdata   (reg_rdata),
        .o_upd         (upd),
        .o_res         (res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_depth     <= '0;
            r_ip        <= '0;
            r_plen      <= '0;
            r_stopped   <= 1'b0;
            r_err       <= ERR_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_plen <= n_plen;
            end
            if (exec_go) begin
                r_depth <= upd.depth;
                r_ip    <= upd.ip;
                if (upd.stop_set) begin
                    r_stopped <= 1'b1;
                    r_err     <= upd.err;
                end
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word     <= i_instr_word;
            r_fwd_t    <= n_fwd_t;
            r_fwd_s    <= n_fwd_s;
            r_fwd_data <= upd.stk_wdata;
        end
        if (exec_go) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_address = r_res.next_address;
    assign o_finished     = r_res.finished;
    assign o_char_valid   = r_res.char_valid;
    assign o_char_value   = r_res.char_value;
    assign o_error_code   = r_res.error_code;

endmodule

// ===== design/bsm_checker.sv =====
// ---------------------------------------------------------------------------
// bsm_checker - port level checks of the executor
// Watches results over time; bound to the top level.
// ---------------------------------------------------------------------------
module bsm_checker
    import bsm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [ADDR_W-1:0] o_next_address,
    input logic              o_finished,
    input logic              o_char_valid,
    input logic [WORD_W-1:0] o_char_value,
    input logic [ERR_W-1:0]  o_error_code
);

    logic             r_seen_err;
    logic [ERR_W-1:0] r_last_err;

    // remember the first fault reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
            r_last_err <= '0;
        end else if (o_out_valid && !i_out_stall && o_error_code != ERR_OK
                     && !r_seen_err) begin
            r_seen_err <= 1'b1;
            r_last_err <= o_error_code;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_next_address)
        && $stable(o_finished) && $stable(o_error_code) && $stable(o_char_value)))
        else $error("stalled result changed");

    // a character is only emitted by a clean step
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_valid) |-> (o_error_code == ERR_OK))
        else $error("character with fault");

    // no character means zero value
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_char_value == '0))
        else $error("character value without character");

    // a fault is sticky
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_seen_err) |-> (o_error_code == r_last_err && !o_char_valid))
        else $error("fault code not held");

endmodule

bind byte_stack_machine_executor_top bsm_checker u_bsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_next_address (o_next_address),
    .o_finished     (o_finished),
    .o_char_valid   (o_char_valid),
    .o_char_value   (o_char_value),
    .o_error_code   (o_error_code)
);
